// ----- src/nnis_pkg.sv -----
// Shared constants, types and helpers for the nearest-neighbor image scaler.
package nnis_pkg;

  localparam int STORE_PIXELS = 65536;
  localparam int MAX_DIM      = 1024;
  localparam int FRAC_BITS    = 16;
  localparam int PIX_W        = 24;
  localparam int DIM_W        = 11;
  localparam int COORD_W      = 10;
  localparam int DIM_RESET    = 256;
  localparam int COUNT_W      = 21;
  localparam int STEP_W       = DIM_W + FRAC_BITS;
  localparam int ADDR_W       = $clog2(STORE_PIXELS);
  localparam int PROD_W       = COORD_W + STEP_W;
  localparam int SRC_COORD_W  = PROD_W - FRAC_BITS;
  localparam int AREA_W       = 2 * DIM_W;
  localparam int IDX_W        = COORD_W + DIM_W;
  localparam int DIV_CNT_W    = $clog2(STEP_W);
  localparam int CFG_IDX_W    = 2;
  localparam int OUT_DATA_W   = ((PIX_W + 2 * COORD_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH,
    CFG_SRC_HEIGHT,
    CFG_DST_WIDTH,
    CFG_DST_HEIGHT
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_MUL,
    ST_CLAMP,
    ST_ADDR,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic load_step;
    logic div_start;
    logic mul;
    logic clamp;
    logic addr;
    logic read;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_full;
    logic div_done;
    logic out_free;
    logic last;
  } dp_sts_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ----- src/nearest_neighbor_image_scaler.sv -----
// Top level of the nearest-neighbor image scaler (11.16 fixed-point steps).
//
// Channel | Dir | Signals                          | Contents
// in_     | in  | tvalid/tready, tdata[23:0], tuser | pixel_in; tuser = func (0 load, 1 request)
// out_    | out | tvalid/tready, tdata[47:0], tlast | pixel_out, out_col, out_row; tlast = last
// cfg_    | in  | we, addr[1:0], wdata[10:0]        | src_width, src_height, dst_width, dst_height
//
// A load transaction passes through capture and load step; the load that completes a frame
// also runs the two bit-serial step dividers (one quotient bit per cycle, 27 bits).
// A request transaction steps through multiply, clamp, address multiply-add,
// frame store read, output register. A stalled output holds the request in its emit step.
// Ignored transactions are accepted and dropped. Synchronous active-low reset; frame store not cleared.
module nearest_neighbor_image_scaler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [nnis_pkg::PIX_W-1:0]      in_tdata,   // [23:0] pixel_in
  input  logic                            in_tuser,   // [0] func
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [nnis_pkg::OUT_DATA_W-1:0] out_tdata,  // [23:0] pixel_out, [33:24] out_col,
                                                      // [43:34] out_row, [47:44] zero
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [nnis_pkg::DIM_W-1:0]      cfg_wdata
);
  import nnis_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  nnis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  nnis_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- src/nnis_div.sv -----
// Restoring divider, one quotient bit per cycle, for the 11.16 scale step.
module nnis_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [nnis_pkg::STEP_W-1:0] dividend,
  input  logic [nnis_pkg::DIM_W-1:0]  divisor,
  output logic [nnis_pkg::STEP_W-1:0] quotient,
  output logic                        done
);
  import nnis_pkg::*;

  logic [STEP_W-1:0]    num_r;
  logic [STEP_W-1:0]    quo_r;
  logic [DIM_W-1:0]     den_r;
  logic [DIM_W-1:0]     rem_r;
  logic [DIM_W-1:0]     rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIM_W:0]       rem_sh;
  logic [DIM_W:0]       rem_sub;
  logic                 fits;

  always_comb begin
    rem_sh  = {rem_r, num_r[STEP_W-1]};
    fits    = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
    rem_nxt = fits ? rem_sub[DIM_W-1:0] : rem_sh[DIM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(STEP_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[STEP_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[STEP_W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ----- src/nnis_ctrl.sv -----
// Controller state machine: sequences loads, step division and pixel requests.
module nnis_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_func,
  output logic              in_tready,
  output nnis_pkg::dp_cmd_t cmd,
  input  nnis_pkg::dp_sts_t sts
);
  import nnis_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   frame_ready_r;
  logic   frame_ready_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      frame_ready_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      frame_ready_r <= frame_ready_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    frame_ready_nxt = frame_ready_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (!in_func && !frame_ready_r) begin
            state_nxt = ST_LOAD;
          end else if (in_func && frame_ready_r) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_LOAD: begin
        state_nxt = sts.frame_full ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt       = ST_IDLE;
          frame_ready_nxt = 1'b1;
        end
      end
      ST_MUL:   state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
          if (sts.last) begin
            frame_ready_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_LOAD: begin
        cmd.load_step = 1'b1;
        cmd.div_start = sts.frame_full;
      end
      ST_DIV:   ;
      ST_MUL:   cmd.mul   = 1'b1;
      ST_CLAMP: cmd.clamp = 1'b1;
      ST_ADDR:  cmd.addr  = 1'b1;
      ST_READ:  cmd.read  = 1'b1;
      ST_EMIT:  cmd.emit  = sts.out_free;
      default:  ;
    endcase
  end

  a_emit_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> frame_ready_r)
    else $error("pixel emitted without a loaded frame");

  a_load_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_step |-> !frame_ready_r)
    else $error("load step while frame ready");

  a_div_arms_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && sts.div_done) |=> frame_ready_r)
    else $error("frame not armed after step division");

  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.last) |=> (!frame_ready_r && state_r == ST_IDLE))
    else $error("last pixel did not rearm loading");

endmodule

// ----- src/nnis_dp.sv -----
// Datapath: config registers, frame store, step dividers, coordinate mapping, output register.
module nnis_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [nnis_pkg::DIM_W-1:0]      cfg_wdata,
  input  logic [nnis_pkg::PIX_W-1:0]      in_tdata,
  input  nnis_pkg::dp_cmd_t               cmd,
  output nnis_pkg::dp_sts_t               sts,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [nnis_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import nnis_pkg::*;

  logic [DIM_W-1:0]       src_w_r;
  logic [DIM_W-1:0]       src_h_r;
  logic [DIM_W-1:0]       dst_w_r;
  logic [DIM_W-1:0]       dst_h_r;
  logic [DIM_W-1:0]       sw_eff;
  logic [DIM_W-1:0]       sh_eff;
  logic [DIM_W-1:0]       dw_eff;
  logic [DIM_W-1:0]       dh_eff;
  logic [AREA_W-1:0]      frame_px_r;
  logic [PIX_W-1:0]       pix_r;
  logic [COUNT_W-1:0]     load_count_r;
  logic [COUNT_W-1:0]     load_count_nxt;
  logic                   store_hit;
  logic [STEP_W-1:0]      x_step;
  logic [STEP_W-1:0]      y_step;
  logic                   x_done;
  logic                   y_done;
  logic [COORD_W-1:0]     col_r;
  logic [COORD_W-1:0]     row_r;
  logic                   col_wrap;
  logic                   row_wrap;
  logic [PROD_W-1:0]      prod_x_r;
  logic [PROD_W-1:0]      prod_y_r;
  logic [SRC_COORD_W-1:0] sx_full;
  logic [SRC_COORD_W-1:0] sy_full;
  logic [DIM_W-1:0]       sx_lim;
  logic [DIM_W-1:0]       sy_lim;
  logic [COORD_W-1:0]     sx_r;
  logic [COORD_W-1:0]     sy_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   in_store_r;
  logic [PIX_W-1:0]       rd_r;
  logic [PIX_W-1:0]       store_mem [STORE_PIXELS];
  logic                   out_tvalid_r;
  logic [OUT_DATA_W-1:0]  out_tdata_r;
  logic                   out_tlast_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= DIM_W'(DIM_RESET);
      src_h_r <= DIM_W'(DIM_RESET);
      dst_w_r <= DIM_W'(DIM_RESET);
      dst_h_r <= DIM_W'(DIM_RESET);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SRC_WIDTH:  src_w_r <= cfg_wdata;
        CFG_SRC_HEIGHT: src_h_r <= cfg_wdata;
        CFG_DST_WIDTH:  dst_w_r <= cfg_wdata;
        CFG_DST_HEIGHT: dst_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign sw_eff = eff_dim(src_w_r);
  assign sh_eff = eff_dim(src_h_r);
  assign dw_eff = eff_dim(dst_w_r);
  assign dh_eff = eff_dim(dst_h_r);

  always_ff @(posedge clk) begin
    frame_px_r <= AREA_W'(sw_eff) * AREA_W'(sh_eff);
  end

  // loading
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_r <= in_tdata;
    end
  end

  assign load_count_nxt = (load_count_r == '1) ? load_count_r : load_count_r + 1'b1;
  assign store_hit      = load_count_r < COUNT_W'(STORE_PIXELS);
  assign sts.frame_full = {1'b0, load_count_nxt} >= frame_px_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
    end else if (cmd.emit && sts.last) begin
      load_count_r <= '0;
    end else if (cmd.load_step) begin
      load_count_r <= load_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_step && store_hit) begin
      store_mem[load_count_r[ADDR_W-1:0]] <= pix_r;
    end
    if (cmd.read) begin
      rd_r <= store_mem[idx_r[ADDR_W-1:0]];
    end
  end

  // 11.16 steps
  nnis_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({sw_eff, FRAC_BITS'(0)}),
    .divisor  (dw_eff),
    .quotient (x_step),
    .done     (x_done)
  );

  nnis_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({sh_eff, FRAC_BITS'(0)}),
    .divisor  (dh_eff),
    .quotient (y_step),
    .done     (y_done)
  );

  assign sts.div_done = x_done && y_done;

  // destination raster
  assign col_wrap = (DIM_W'(col_r) + DIM_W'(1)) >= dw_eff;
  assign row_wrap = (DIM_W'(row_r) + DIM_W'(1)) >= dh_eff;
  assign sts.last = col_wrap && row_wrap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.div_start) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.emit) begin
      if (col_wrap) begin
        col_r <= '0;
        row_r <= row_wrap ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // source mapping
  assign sx_full = prod_x_r[PROD_W-1:FRAC_BITS];
  assign sy_full = prod_y_r[PROD_W-1:FRAC_BITS];
  assign sx_lim  = sw_eff - 1'b1;
  assign sy_lim  = sh_eff - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_x_r <= PROD_W'(col_r) * PROD_W'(x_step);
      prod_y_r <= PROD_W'(row_r) * PROD_W'(y_step);
    end
    if (cmd.clamp) begin
      sx_r <= (sx_full > SRC_COORD_W'(sx_lim)) ? COORD_W'(sx_lim) : COORD_W'(sx_full);
      sy_r <= (sy_full > SRC_COORD_W'(sy_lim)) ? COORD_W'(sy_lim) : COORD_W'(sy_full);
    end
    if (cmd.addr) begin
      idx_r <= IDX_W'(sy_r) * IDX_W'(sw_eff) + IDX_W'(sx_r);
    end
    if (cmd.read) begin
      in_store_r <= idx_r < IDX_W'(STORE_PIXELS);
    end
  end

  // output register
  assign sts.out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tdata_r <= OUT_DATA_W'({row_r, col_r, (in_store_r ? rd_r : PIX_W'(0))});
      out_tlast_r <= sts.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ----- dv/nearest_neighbor_image_scaler_test.sv -----
// Self-checking testbench for the nearest-neighbor image scaler: stream driver, monitor, predictor.
`timescale 1ns / 100ps

module nearest_neighbor_image_scaler_test;
  import nnis_pkg::*;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;
  localparam int   HOLD_CYCLES  = 400;
  localparam int   SETTLE_CYCLES = 64;
  localparam int   CYCLE_LIMIT  = 2_000_000;
  localparam int   RAND_ITEMS   = 400;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] pixel;
  } scaler_cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } scaled_px_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_addr = CFG_SRC_WIDTH;
  logic [DIM_W-1:0]      cfg_wdata = '0;

  nearest_neighbor_image_scaler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  scaler_cmd_t pixel_cmd_q [$];
  scaled_px_t  scaled_q [$];

  int send_idle = 0;
  int recv_idle = 0;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int cycle_cnt = 0;
  int mismatches = 0;
  int rand_items = 0;

  // predictor state
  logic [DIM_W-1:0]   cfg_regs [4];
  logic [PIX_W-1:0]   src_frame [0:STORE_PIXELS-1];
  logic [COUNT_W-1:0] loaded_px;
  logic               frame_full;
  logic [STEP_W-1:0]  h_step;
  logic [STEP_W-1:0]  v_step;
  logic [COORD_W-1:0] next_col;
  logic [COORD_W-1:0] next_row;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  function automatic int eff(input int v);
    return int'(clamp_dim(DIM_W'(v)));
  endfunction

  function automatic void reset_model();
    cfg_regs[CFG_SRC_WIDTH]  = DIM_W'(DIM_RESET);
    cfg_regs[CFG_SRC_HEIGHT] = DIM_W'(DIM_RESET);
    cfg_regs[CFG_DST_WIDTH]  = DIM_W'(DIM_RESET);
    cfg_regs[CFG_DST_HEIGHT] = DIM_W'(DIM_RESET);
    loaded_px  = '0;
    frame_full = 1'b0;
    h_step     = '0;
    v_step     = '0;
    next_col   = '0;
    next_row   = '0;
  endfunction

  function automatic void apply_item(input logic func, input logic [PIX_W-1:0] pix);
    logic [DIM_W-1:0] sw, sh, dw, dh;
    logic [63:0]      sx, sy, idx;
    scaled_px_t       px;
    sw = clamp_dim(cfg_regs[CFG_SRC_WIDTH]);
    sh = clamp_dim(cfg_regs[CFG_SRC_HEIGHT]);
    dw = clamp_dim(cfg_regs[CFG_DST_WIDTH]);
    dh = clamp_dim(cfg_regs[CFG_DST_HEIGHT]);
    if (func == FUNC_LOAD) begin
      if (!frame_full) begin
        if (loaded_px < STORE_PIXELS) src_frame[loaded_px[ADDR_W-1:0]] = pix;
        if (loaded_px != '1) loaded_px = loaded_px + 1'b1;
        if (64'(loaded_px) >= 64'(sw) * 64'(sh)) begin
          frame_full = 1'b1;
          h_step     = STEP_W'((64'(sw) << FRAC_BITS) / 64'(dw));
          v_step     = STEP_W'((64'(sh) << FRAC_BITS) / 64'(dh));
          next_col   = '0;
          next_row   = '0;
        end
      end
    end else if (frame_full) begin
      sx = (64'(next_col) * 64'(h_step)) >> FRAC_BITS;
      sy = (64'(next_row) * 64'(v_step)) >> FRAC_BITS;
      if (sx > 64'(sw) - 1) sx = 64'(sw) - 1;
      if (sy > 64'(sh) - 1) sy = 64'(sh) - 1;
      idx = sy * 64'(sw) + sx;
      px.pixel = (idx < STORE_PIXELS) ? src_frame[idx[ADDR_W-1:0]] : '0;
      px.col   = next_col;
      px.row   = next_row;
      px.last  = 1'b0;
      if (32'(next_col) + 1 >= 32'(dw)) begin
        if (32'(next_row) + 1 >= 32'(dh)) begin
          px.last    = 1'b1;
          frame_full = 1'b0;
          loaded_px  = '0;
          next_col   = '0;
          next_row   = '0;
        end else begin
          next_col = '0;
          next_row = next_row + 1'b1;
        end
      end else begin
        next_col = next_col + 1'b1;
      end
      scaled_q.push_back(px);
    end
  endfunction

  // input driver
  always @(posedge clk) begin : drive_in
    scaler_cmd_t cmd;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) apply_item(in_tuser, in_tdata);
      if (!in_tvalid || in_tready) begin
        if (pixel_cmd_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          cmd = pixel_cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= cmd.pixel;
          in_tuser  <= cmd.func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver with long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_go) begin
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // output monitor
  always @(posedge clk) begin : mon_out
    scaled_px_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.pixel = out_tdata[PIX_W-1:0];
      got.col   = out_tdata[PIX_W +: COORD_W];
      got.row   = out_tdata[PIX_W + COORD_W +: COORD_W];
      got.last  = out_tlast;
      if (scaled_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: pixel %h col %0d row %0d last %b",
                   got.pixel, got.col, got.row, got.last);
      end else begin
        want = scaled_q.pop_front();
        if (got.pixel !== want.pixel || got.col !== want.col ||
            got.row !== want.row || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp pixel %h col %0d row %0d last %b,",
                     want.pixel, want.col, want.row, want.last,
                     " got pixel %h col %0d row %0d last %b",
                     got.pixel, got.col, got.row, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_item(input logic func, input logic [PIX_W-1:0] pix);
    scaler_cmd_t cmd;
    cmd.func  = func;
    cmd.pixel = pix;
    pixel_cmd_q.push_back(cmd);
  endtask

  task automatic push_loads(input int n);
    for (int i = 0; i < n; i++) push_item(FUNC_LOAD, PIX_W'($urandom()));
  endtask

  // noise loads land while the frame is full, never after the last request
  task automatic push_requests(input int n);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(15) == 0) push_item(FUNC_LOAD, PIX_W'($urandom()));
      push_item(FUNC_REQUEST, PIX_W'($urandom()));
    end
  endtask

  task automatic wait_sent();
    do @(negedge clk); while (pixel_cmd_q.size() != 0 || in_tvalid);
  endtask

  task automatic settle();
    do @(negedge clk); while (pixel_cmd_q.size() != 0 || in_tvalid || scaled_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= DIM_W'(value);
    cfg_regs[idx] = DIM_W'(value);
  endtask

  task automatic write_dims(input int sw, input int sh, input int dw, input int dh);
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_frame(input int sw, input int sh, input int dw, input int dh);
    settle();
    write_dims(sw, sh, dw, dh);
    push_loads(eff(sw) * eff(sh));
    push_requests(eff(dw) * eff(dh));
  endtask

  function automatic int pick_dim();
    if ($urandom_range(15) == 0) return 0;
    return $urandom_range(1, 9);
  endfunction

  task automatic run_random_frame(input bit pressure);
    int sw, sh, dw, dh, n, cut;
    sw = pick_dim();
    sh = pick_dim();
    dw = pick_dim();
    dh = pick_dim();
    if (pressure) dw = $urandom_range(2, 9);
    settle();
    write_dims(sw, sh, dw, dh);
    if ($urandom_range(3) == 0) begin
      for (int i = $urandom_range(1, 3); i > 0; i--) push_item(FUNC_REQUEST, PIX_W'($urandom()));
    end
    n = eff(sw) * eff(sh);
    if (n > 1 && $urandom_range(4) == 0) begin
      // partial frame, then new source shape
      cut = $urandom_range(1, n - 1);
      push_loads(cut);
      rand_items += cut;
      settle();
      sw = pick_dim();
      sh = pick_dim();
      write_dims(sw, sh, dw, dh);
      n = eff(sw) * eff(sh);
      n = (n > int'(loaded_px)) ? n - int'(loaded_px) : 1;
    end
    push_loads(n);
    if (pressure) begin
      do @(negedge clk); while (!frame_full);
      hold_go = 1'b1;
      @(negedge clk);
      hold_go = 1'b0;
    end
    push_requests(eff(dw) * eff(dh));
    rand_items += n + eff(dw) * eff(dh);
  endtask

  initial begin : stim
    bit pressed;
    pressed = 1'b0;
    reset_model();
    send_idle = 18;
    recv_idle = 68;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // upscale 2x2 -> 3x3, request before ready, load while ready, pixel extremes
    write_dims(2, 2, 3, 3);
    push_item(FUNC_REQUEST, '1);
    push_item(FUNC_LOAD, '0);
    push_item(FUNC_LOAD, '1);
    push_item(FUNC_LOAD, 24'hA5A5A5);
    push_item(FUNC_LOAD, 24'h5A5A5A);
    push_item(FUNC_LOAD, 24'h123456);
    for (int i = 0; i < 9; i++) push_item(FUNC_REQUEST, '0);

    // zero dimensions act as one
    run_frame(0, 1, 2, 0);

    // reshape while the frame is full
    settle();
    write_dims(3, 2, 2, 3);
    push_loads(6);
    for (int i = 0; i < 3; i++) push_item(FUNC_REQUEST, PIX_W'($urandom()));
    settle();
    write_dims(2, 1, 4, 1);
    while (frame_full) begin
      push_item(FUNC_REQUEST, PIX_W'($urandom()));
      wait_sent();
    end

    // destination width saturates to 1024: column 32 maps to source column 1
    settle();
    write_dims(32, 1, 2047, 1);
    push_loads(32);
    for (int i = 0; i < 33; i++) push_item(FUNC_REQUEST, PIX_W'($urandom()));
    settle();
    write_dims(32, 1, 34, 1);
    push_item(FUNC_REQUEST, PIX_W'($urandom()));

    while (rand_items < RAND_ITEMS || !pressed) begin
      if (rand_items < RAND_ITEMS / 3) begin
        send_idle = 18;
        recv_idle = 68;
      end else if (rand_items < 2 * RAND_ITEMS / 3) begin
        send_idle = 68;
        recv_idle = 18;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      run_random_frame(send_idle == 0 && !pressed);
      if (send_idle == 0) pressed = 1'b1;
    end

    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/nnis_pkg.sv
src/nnis_div.sv
src/nnis_ctrl.sv
src/nnis_dp.sv
src/nearest_neighbor_image_scaler.sv
dv/nearest_neighbor_image_scaler_test.sv
